@@ src/priority_deque_with_search_top_defines.svh @@
// assertion macros for the checker of the deque block
`ifndef PRIORITY_DEQUE_WITH_SEARCH_TOP_DEFINES_SVH
`define PRIORITY_DEQUE_WITH_SEARCH_TOP_DEFINES_SVH

// property checked only while out of reset
`define PDQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// property checked at every edge, reset included
`define PDQ_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ src/pdq_pkg.sv @@
package pdq_pkg;

   // queue geometry
   localparam int QUEUE_DEPTH = 64;
   localparam int COUNT_WIDTH = 16;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int POS_W       = IDX_W;
   localparam logic [IDX_W:0] DEPTH_WIDE = (IDX_W + 1)'(QUEUE_DEPTH);

   // field widths
   localparam int CMD_W    = 3;
   localparam int ID_W     = 31;
   localparam int YEAR_W   = 12;
   localparam int LIMIT_W  = 8;
   localparam int STATUS_W = 2;
   localparam int ENTRY_W  = ID_W + YEAR_W;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = YEAR_W;

   // register reset values
   localparam logic [YEAR_W-1:0]  REF_YEAR_RESET  = YEAR_W'(2019);
   localparam logic [LIMIT_W-1:0] AGE_LIMIT_RESET = LIMIT_W'(65);

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT    = 3'd0,
      CMD_PRIORITY_PUSH = 3'd1,
      CMD_POP_FRONT     = 3'd2,
      CMD_POP_BACK      = 3'd3,
      CMD_FIND          = 3'd4,
      CMD_READ_COUNTS   = 3'd5
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REFERENCE_YEAR = 1'd0,
      CSR_AGE_LIMIT      = 1'd1
   } csr_index_type;

   // controller to datapath
   typedef struct packed {
      logic       take_item;
      logic       push;
      logic       rd_pop;
      logic       pop;
      logic       rd_first;
      logic       rd_next;
      logic       found;
      logic       fail;
      status_type fail_code;
      logic       emit;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_push;
      logic is_pop;
      logic is_find;
      logic full;
      logic empty;
      logic hit;
      logic last;
      logic out_free;
   } dp_status_type;

   // circular slot arithmetic: base plus offset, offset at most the depth
   function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W:0]   offset);
      logic [IDX_W:0] sum;
      sum = {1'b0, base} + offset;
      if (sum >= DEPTH_WIDE) begin
         sum = sum - DEPTH_WIDE;
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

@@ src/pdq_ifs.sv @@
// request channel: one command per beat
interface pdq_req_if;
   import pdq_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [ID_W-1:0]   entry_id;
   logic [YEAR_W-1:0] birth_year;

   modport source (output valid, command, entry_id, birth_year, input ready);
   modport sink   (input valid, command, entry_id, birth_year, output ready);
endinterface

// response channel: one result per beat
interface pdq_rsp_if;
   import pdq_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic                   went_to_front;
   logic [ID_W-1:0]        out_id;
   logic [YEAR_W-1:0]      out_birth_year;
   logic [POS_W-1:0]       found_position;
   logic [OCC_W-1:0]       waiting_count;
   logic [COUNT_WIDTH-1:0] served_count;
   logic [COUNT_WIDTH-1:0] left_early_count;

   modport source (output valid, status, went_to_front, out_id, out_birth_year,
                   found_position, waiting_count, served_count, left_early_count,
                   input ready);
   modport sink   (input valid, status, went_to_front, out_id, out_birth_year,
                   found_position, waiting_count, served_count, left_early_count,
                   output ready);
endinterface

@@ src/pdq_ctrl.sv @@
module pdq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  pdq_pkg::dp_status_type dp_status,
   output pdq_pkg::ctrl_cmd_type  dp_cmd
);
   import pdq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_POP,
      S_SCAN,
      S_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and datapath commands
   always_comb begin
      state_in  = state_ff;
      dp_cmd    = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready        = 1'b1;
            dp_cmd.take_item = req_valid;
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_EMIT;
            if (dp_status.is_push) begin
               if (dp_status.full) begin
                  dp_cmd.fail      = 1'b1;
                  dp_cmd.fail_code = ST_FULL;
               end else begin
                  dp_cmd.push = 1'b1;
               end
            end else if (dp_status.is_pop || dp_status.is_find) begin
               if (dp_status.empty) begin
                  dp_cmd.fail      = 1'b1;
                  dp_cmd.fail_code = ST_EMPTY;
               end else if (dp_status.is_pop) begin
                  dp_cmd.rd_pop = 1'b1;
                  state_in      = S_POP;
               end else begin
                  dp_cmd.rd_first = 1'b1;
                  state_in        = S_SCAN;
               end
            end
         end
         S_POP: begin
            dp_cmd.pop = 1'b1;
            state_in   = S_EMIT;
         end
         S_SCAN: begin
            if (dp_status.hit) begin
               dp_cmd.found = 1'b1;
               state_in     = S_EMIT;
            end else if (dp_status.last) begin
               dp_cmd.fail      = 1'b1;
               dp_cmd.fail_code = ST_NOT_FOUND;
               state_in         = S_EMIT;
            end else begin
               dp_cmd.rd_next = 1'b1;
            end
         end
         S_EMIT: begin
            if (dp_status.out_free) begin
               dp_cmd.emit = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ src/pdq_dpath.sv @@
module pdq_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [pdq_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pdq_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic [pdq_pkg::CMD_W-1:0]           req_command,
   input  logic [pdq_pkg::ID_W-1:0]            req_entry_id,
   input  logic [pdq_pkg::YEAR_W-1:0]          req_birth_year,
   input  pdq_pkg::ctrl_cmd_type               dp_cmd,
   output pdq_pkg::dp_status_type              dp_status,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [pdq_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                rsp_went_to_front,
   output logic [pdq_pkg::ID_W-1:0]            rsp_out_id,
   output logic [pdq_pkg::YEAR_W-1:0]          rsp_out_birth_year,
   output logic [pdq_pkg::POS_W-1:0]           rsp_found_position,
   output logic [pdq_pkg::OCC_W-1:0]           rsp_waiting_count,
   output logic [pdq_pkg::COUNT_WIDTH-1:0]     rsp_served_count,
   output logic [pdq_pkg::COUNT_WIDTH-1:0]     rsp_left_early_count
);
   import pdq_pkg::*;

   // configuration registers
   logic [YEAR_W-1:0]  ref_year_ff, ref_year_in;
   logic [LIMIT_W-1:0] age_limit_ff, age_limit_in;

   // current item
   command_type       cmd_ff, cmd_in;
   logic [ID_W-1:0]   key_ff, key_in;
   logic [YEAR_W-1:0] year_ff, year_in;

   // queue state
   logic [IDX_W-1:0]       head_ff, head_in;
   logic [OCC_W-1:0]       occ_ff, occ_in;
   logic [COUNT_WIDTH-1:0] served_ff, served_in;
   logic [COUNT_WIDTH-1:0] left_ff, left_in;
   logic [IDX_W-1:0]       scan_ff, scan_in;

   // result under construction
   status_type        res_status_ff, res_status_in;
   logic              res_front_ff, res_front_in;
   logic [ID_W-1:0]   res_id_ff, res_id_in;
   logic [YEAR_W-1:0] res_year_ff, res_year_in;
   logic [POS_W-1:0]  res_pos_ff, res_pos_in;

   // output register
   logic                   out_valid_ff, out_valid_in;
   status_type             out_status_ff, out_status_in;
   logic                   out_front_ff, out_front_in;
   logic [ID_W-1:0]        out_id_ff, out_id_in;
   logic [YEAR_W-1:0]      out_year_ff, out_year_in;
   logic [POS_W-1:0]       out_pos_ff, out_pos_in;
   logic [OCC_W-1:0]       out_occ_ff, out_occ_in;
   logic [COUNT_WIDTH-1:0] out_served_ff, out_served_in;
   logic [COUNT_WIDTH-1:0] out_left_ff, out_left_in;

   // entry memory
   logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
   logic [ENTRY_W-1:0] mem_rd_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic [IDX_W-1:0]   wr_addr;
   logic               wr_en;

   logic                    is_push, is_pop, is_find, is_pop_front;
   logic                    to_head;
   logic signed [YEAR_W+1:0] age;
   logic [IDX_W-1:0]        head_slot, tail_slot, back_slot;
   logic [ID_W-1:0]         rd_id;
   logic [YEAR_W-1:0]       rd_year;

   // command decode
   always_comb begin
      is_push      = 1'b0;
      is_pop       = 1'b0;
      is_find      = 1'b0;
      is_pop_front = 1'b0;
      case (cmd_ff)
         CMD_PUSH_FRONT, CMD_PRIORITY_PUSH: is_push = 1'b1;
         CMD_POP_FRONT: begin
            is_pop       = 1'b1;
            is_pop_front = 1'b1;
         end
         CMD_POP_BACK: is_pop  = 1'b1;
         CMD_FIND:     is_find = 1'b1;
         default: begin
            is_push = 1'b0;
         end
      endcase
   end

   // age rule: push-front, or a signed age above the limit, goes to the head
   assign age = $signed({2'b00, ref_year_ff}) - $signed({2'b00, year_ff});
   assign to_head = (cmd_ff == CMD_PUSH_FRONT) ||
                    (age > $signed((YEAR_W + 2)'(age_limit_ff)));

   // slot addresses
   assign head_slot = slot_add(head_ff, DEPTH_WIDE - (IDX_W + 1)'(1));
   assign tail_slot = slot_add(head_ff, (IDX_W + 1)'(occ_ff));
   assign back_slot = slot_add(head_ff, (IDX_W + 1)'(occ_ff - OCC_W'(1)));

   assign wr_en   = dp_cmd.push;
   assign wr_addr = to_head ? head_slot : tail_slot;

   always_comb begin
      if (dp_cmd.rd_pop) begin
         rd_addr = is_pop_front ? head_ff : back_slot;
      end else if (dp_cmd.rd_next) begin
         rd_addr = slot_add(head_ff, (IDX_W + 1)'(scan_ff) + (IDX_W + 1)'(1));
      end else begin
         rd_addr = head_ff;
      end
   end

   // memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {key_ff, year_ff};
      end
      mem_rd_ff <= mem[rd_addr];
   end

   assign rd_id   = mem_rd_ff[ENTRY_W-1:YEAR_W];
   assign rd_year = mem_rd_ff[YEAR_W-1:0];

   // status to the controller
   assign dp_status.is_push  = is_push;
   assign dp_status.is_pop   = is_pop;
   assign dp_status.is_find  = is_find;
   assign dp_status.full     = (occ_ff == OCC_W'(QUEUE_DEPTH));
   assign dp_status.empty    = (occ_ff == '0);
   assign dp_status.hit      = (rd_id == key_ff);
   assign dp_status.last     = (OCC_W'(scan_ff) == occ_ff - OCC_W'(1));
   assign dp_status.out_free = !out_valid_ff || rsp_ready;

   // configuration writes
   always_comb begin
      ref_year_in  = ref_year_ff;
      age_limit_in = age_limit_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_REFERENCE_YEAR: ref_year_in  = csr_wdata[YEAR_W-1:0];
            CSR_AGE_LIMIT:      age_limit_in = csr_wdata[LIMIT_W-1:0];
            default: begin
               ref_year_in = ref_year_ff;
            end
         endcase
      end
   end

   // item capture and scan index
   always_comb begin
      cmd_in  = cmd_ff;
      key_in  = key_ff;
      year_in = year_ff;
      scan_in = scan_ff;
      if (dp_cmd.take_item) begin
         cmd_in  = command_type'(req_command);
         key_in  = req_entry_id;
         year_in = req_birth_year;
      end
      if (dp_cmd.rd_first) begin
         scan_in = '0;
      end else if (dp_cmd.rd_next) begin
         scan_in = scan_ff + IDX_W'(1);
      end
   end

   // queue state updates
   always_comb begin
      head_in   = head_ff;
      occ_in    = occ_ff;
      served_in = served_ff;
      left_in   = left_ff;
      if (dp_cmd.push) begin
         if (to_head) begin
            head_in = head_slot;
         end
         occ_in = occ_ff + OCC_W'(1);
      end
      if (dp_cmd.pop) begin
         occ_in = occ_ff - OCC_W'(1);
         if (is_pop_front) begin
            head_in = slot_add(head_ff, (IDX_W + 1)'(1));
            if (served_ff != '1) begin
               served_in = served_ff + COUNT_WIDTH'(1);
            end
         end else if (left_ff != '1) begin
            left_in = left_ff + COUNT_WIDTH'(1);
         end
      end
   end

   // result fields
   always_comb begin
      res_status_in = res_status_ff;
      res_front_in  = res_front_ff;
      res_id_in     = res_id_ff;
      res_year_in   = res_year_ff;
      res_pos_in    = res_pos_ff;
      if (dp_cmd.take_item) begin
         res_status_in = ST_OK;
         res_front_in  = 1'b0;
         res_id_in     = '0;
         res_year_in   = '0;
         res_pos_in    = '0;
      end
      if (dp_cmd.push) begin
         res_front_in = to_head;
      end
      if (dp_cmd.pop || dp_cmd.found) begin
         res_id_in   = rd_id;
         res_year_in = rd_year;
      end
      if (dp_cmd.found) begin
         res_pos_in = scan_ff;
      end
      if (dp_cmd.fail) begin
         res_status_in = dp_cmd.fail_code;
      end
   end

   // output register: loads a finished result, frees on a taken beat
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_front_in  = out_front_ff;
      out_id_in     = out_id_ff;
      out_year_in   = out_year_ff;
      out_pos_in    = out_pos_ff;
      out_occ_in    = out_occ_ff;
      out_served_in = out_served_ff;
      out_left_in   = out_left_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (dp_cmd.emit) begin
         out_valid_in  = 1'b1;
         out_status_in = res_status_ff;
         out_front_in  = res_front_ff;
         out_id_in     = res_id_ff;
         out_year_in   = res_year_ff;
         out_pos_in    = res_pos_ff;
         out_occ_in    = occ_ff;
         out_served_in = served_ff;
         out_left_in   = left_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_year_ff  <= REF_YEAR_RESET;
         age_limit_ff <= AGE_LIMIT_RESET;
         head_ff      <= '0;
         occ_ff       <= '0;
         served_ff    <= '0;
         left_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         ref_year_ff  <= ref_year_in;
         age_limit_ff <= age_limit_in;
         head_ff      <= head_in;
         occ_ff       <= occ_in;
         served_ff    <= served_in;
         left_ff      <= left_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      year_ff       <= year_in;
      scan_ff       <= scan_in;
      res_status_ff <= res_status_in;
      res_front_ff  <= res_front_in;
      res_id_ff     <= res_id_in;
      res_year_ff   <= res_year_in;
      res_pos_ff    <= res_pos_in;
      out_status_ff <= out_status_in;
      out_front_ff  <= out_front_in;
      out_id_ff     <= out_id_in;
      out_year_ff   <= out_year_in;
      out_pos_ff    <= out_pos_in;
      out_occ_ff    <= out_occ_in;
      out_served_ff <= out_served_in;
      out_left_ff   <= out_left_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_status           = out_status_ff;
   assign rsp_went_to_front    = out_front_ff;
   assign rsp_out_id           = out_id_ff;
   assign rsp_out_birth_year   = out_year_ff;
   assign rsp_found_position   = out_pos_ff;
   assign rsp_waiting_count    = out_occ_ff;
   assign rsp_served_count     = out_served_ff;
   assign rsp_left_early_count = out_left_ff;

endmodule

@@ src/priority_deque_with_search_top.sv @@
// path from request beat to response valid: push, read counts and failed commands go
// through decode and emit, pops through decode, pop and emit, and a find through decode,
// scan and emit; the scan reads one slot per cycle until a hit or the last slot
// one item at a time: the next request beat is taken only after the result is loaded,
// so no new item enters before the last is through; a held response delays the load
// synchronous reset empties the queue, zeroes totals, restores year 2019 and limit 65
module priority_deque_with_search_top (
   input  logic                              clock,
   input  logic                              reset,
   pdq_req_if.sink                           req_bus,
   pdq_rsp_if.source                         rsp_bus,
   input  logic                              csr_we,
   input  logic [pdq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pdq_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import pdq_pkg::*;

   ctrl_cmd_type  dp_cmd;
   dp_status_type dp_status;

   // sequencer
   pdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   // storage, counters and output register
   pdq_dpath u_dpath (
      .clock                (clock),
      .reset                (reset),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_command          (req_bus.command),
      .req_entry_id         (req_bus.entry_id),
      .req_birth_year       (req_bus.birth_year),
      .dp_cmd               (dp_cmd),
      .dp_status            (dp_status),
      .rsp_ready            (rsp_bus.ready),
      .rsp_valid            (rsp_bus.valid),
      .rsp_status           (rsp_bus.status),
      .rsp_went_to_front    (rsp_bus.went_to_front),
      .rsp_out_id           (rsp_bus.out_id),
      .rsp_out_birth_year   (rsp_bus.out_birth_year),
      .rsp_found_position   (rsp_bus.found_position),
      .rsp_waiting_count    (rsp_bus.waiting_count),
      .rsp_served_count     (rsp_bus.served_count),
      .rsp_left_early_count (rsp_bus.left_early_count)
   );

endmodule

@@ src/pdq_checker.sv @@
`include "priority_deque_with_search_top_defines.svh"

module pdq_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [pdq_pkg::STATUS_W-1:0]  rsp_status,
   input logic                          rsp_went_to_front,
   input logic [pdq_pkg::ID_W-1:0]      rsp_out_id,
   input logic [pdq_pkg::POS_W-1:0]     rsp_found_position,
   input logic [pdq_pkg::OCC_W-1:0]     rsp_waiting_count
);
   import pdq_pkg::*;

   // a stalled response beat keeps its result
   `PDQ_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_out_id), "response changed while stalled")

   // nothing is offered right after reset
   `PDQ_ASSERT_ALWAYS(a_reset_quiet, $past(reset) |-> !rsp_valid, "response valid after reset")

   // an empty report comes only from an empty queue and carries no entry
   `PDQ_ASSERT(a_empty_fields, rsp_valid && rsp_status == ST_EMPTY |-> rsp_waiting_count == '0 && rsp_out_id == '0 && !rsp_went_to_front, "bad empty response")

   // a full report means the queue holds every slot and nothing was placed
   `PDQ_ASSERT(a_full_fields, rsp_valid && rsp_status == ST_FULL |-> rsp_waiting_count == OCC_W'(QUEUE_DEPTH) && !rsp_went_to_front, "bad full response")

   // a miss scans a non-empty queue and reports no entry
   `PDQ_ASSERT(a_miss_fields, rsp_valid && rsp_status == ST_NOT_FOUND |-> rsp_waiting_count != '0 && rsp_out_id == '0 && rsp_found_position == '0, "bad not-found response")

endmodule

bind priority_deque_with_search_top pdq_checker u_pdq_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_status         (rsp_bus.status),
   .rsp_went_to_front  (rsp_bus.went_to_front),
   .rsp_out_id         (rsp_bus.out_id),
   .rsp_found_position (rsp_bus.found_position),
   .rsp_waiting_count  (rsp_bus.waiting_count)
);
